/* design/rrl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl_pkg
// Shared types and constants of the row run-length min-RMS select unit.
// ----------------------------------------------------------------------------
package rrl_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned MAX_ROWS_DEF  = 1024;

    localparam int unsigned LEN_W   = 11;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned SUM_W   = 21;
    localparam int unsigned ROW_W   = 10;
    localparam int unsigned MIN_W   = 10;
    localparam int unsigned RMS_W   = 11;
    localparam int unsigned SCORE_W = 18;
    localparam int unsigned CFG_A_W = 2;
    localparam int unsigned CFG_D_W = 11;

    localparam logic [CNT_W-1:0]   COUNT_CAP = 11'd2047;
    localparam logic [SUM_W-1:0]   SUM_CAP   = 21'h1FFFFF;
    localparam logic [SCORE_W-1:0] SCORE_CAP = 18'h3FFFF;

    localparam logic [CFG_A_W-1:0] REG_MIN_RUNS = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_MAX_RMS  = 2'd1;

    localparam int unsigned QUEUE_DEPTH = 4;

    // one finished row as handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] runs;
        logic             frame_end;
    } t_row_rec;

endpackage

/* design/rrl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl_front
// Per-pixel run tracker: closes runs, sums squared lengths, emits row records.
// ----------------------------------------------------------------------------
module rrl_front #(
    parameter int unsigned MAX_WIDTH = rrl_pkg::MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_pixel,
    input  logic              i_last_in_row,
    input  logic              i_last_in_frame,
    output logic              o_rec_valid,
    output rrl_pkg::t_row_rec o_rec
);
    import rrl_pkg::*;

    localparam int unsigned RUN_CAP_I = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam logic [LEN_W-1:0] RUN_CAP = LEN_W'(RUN_CAP_I);

    logic             r_started, n_started;
    logic             r_prev,    n_prev;
    logic [LEN_W-1:0] r_len,     n_len;
    logic [CNT_W-1:0] r_runs,    n_runs;
    logic [SUM_W-1:0] r_sum,     n_sum;

    logic [2*LEN_W-1:0] sq;
    logic [SUM_W+1:0]   sum_ext;
    logic               row_end;

    assign sq      = {{LEN_W{1'b0}}, r_len} * {{LEN_W{1'b0}}, r_len};
    assign sum_ext = {1'b0, r_sum} + (SUM_W+2)'(sq);
    assign row_end = i_last_in_row | i_last_in_frame;

    always_comb begin
        n_started = r_started;
        n_prev    = r_prev;
        n_len     = r_len;
        n_runs    = r_runs;
        n_sum     = r_sum;
        if (i_accept) begin
            if (!r_started) begin
                n_started = 1'b1;
                n_len     = LEN_W'(1);
            end else if (i_pixel == r_prev) begin
                if (r_len < RUN_CAP) begin
                    n_len = r_len + LEN_W'(1);
                end
            end else begin
                // close the run that just ended
                n_sum = (sum_ext > (SUM_W+2)'(SUM_CAP)) ? SUM_CAP : sum_ext[SUM_W-1:0];
                if (r_runs < COUNT_CAP) begin
                    n_runs = r_runs + CNT_W'(1);
                end
                n_len = LEN_W'(1);
            end
            n_prev = i_pixel;
        end
    end

    assign o_rec_valid     = i_accept & row_end;
    assign o_rec.sum       = n_sum;
    assign o_rec.runs      = n_runs;
    assign o_rec.frame_end = i_last_in_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_prev    <= 1'b0;
            r_len     <= LEN_W'(1);
            r_runs    <= '0;
            r_sum     <= '0;
        end else begin
            r_prev <= n_prev;
            if (o_rec_valid) begin
                // open run at row end is dropped
                r_started <= 1'b0;
                r_len     <= LEN_W'(1);
                r_runs    <= '0;
                r_sum     <= '0;
            end else begin
                r_started <= n_started;
                r_len     <= n_len;
                r_runs    <= n_runs;
                r_sum     <= n_sum;
            end
        end
    end

endmodule

/* design/rrl_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl_queue
// Small register queue of row records between front and back.
// ----------------------------------------------------------------------------
module rrl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  rrl_pkg::t_row_rec i_data,
    input  logic              i_rd,
    output rrl_pkg::t_row_rec o_data,
    output logic              o_full,
    output logic              o_empty
);
    import rrl_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_row_rec         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr & ~o_full;
    assign rd_en   = i_rd & ~o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= r_wp + PTR_W'(1);
            if (rd_en) r_rp <= r_rp + PTR_W'(1);
            r_cnt <= r_cnt + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
        end
    end

endmodule

/* design/rrl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl_back
// Row scoring and best-row select; frame-end divide, square root and result.
// ----------------------------------------------------------------------------
module rrl_back #(
    parameter int unsigned MAX_ROWS = rrl_pkg::MAX_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rrl_pkg::MIN_W-1:0]    i_min_runs,
    input  logic [rrl_pkg::RMS_W-1:0]    i_max_rms,
    input  logic                         i_q_empty,
    input  rrl_pkg::t_row_rec            i_q_data,
    output logic                         o_q_rd,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_any_candidate,
    output logic                         o_found,
    output logic [rrl_pkg::ROW_W-1:0]    o_best_row,
    output logic [rrl_pkg::SCORE_W-1:0]  o_best_score_q8
);
    import rrl_pkg::*;

    localparam int unsigned ROW_CAP_I = ((MAX_ROWS - 1) < 1023) ? (MAX_ROWS - 1) : 1023;
    localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'(ROW_CAP_I);
    localparam int unsigned Q_W = SUM_W + 16;
    localparam int unsigned R_W = Q_W + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_CMP  = 8'b0000_0100,
        S_FND1 = 8'b0000_1000,
        S_FND2 = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_SQRT = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state           r_state;
    t_row_rec         r_rec;
    logic [ROW_W-1:0] r_row;
    logic             r_bv;
    logic [SUM_W-1:0] r_bsum;
    logic [CNT_W-1:0] r_bcnt;
    logic [ROW_W-1:0] r_brow;
    logic [31:0]      r_lhs, r_rhs;
    logic [2*RMS_W-1:0]     r_m2;
    logic [2*RMS_W+CNT_W-1:0] r_m3;
    logic [CNT_W:0]   r_rem;
    logic [Q_W-1:0]   r_q;
    logic [5:0]       r_cnt;
    logic [Q_W-1:0]   r_v;
    logic [R_W-1:0]   r_res, r_bit;
    logic             r_out_valid;
    logic             r_any, r_found;
    logic [ROW_W-1:0] r_orow;
    logic [SCORE_W-1:0] r_oscore;

    logic [CNT_W-1:0] den;
    logic             qual, take;
    logic [CNT_W:0]   rem_sh;
    logic             q_bit;
    logic [R_W-1:0]   trial;

    assign den    = r_bcnt - CNT_W'(1);
    assign qual   = r_rec.runs > {1'b0, i_min_runs};
    assign take   = qual & (~r_bv | (r_lhs < r_rhs));
    assign rem_sh = {r_rem[CNT_W-1:0], r_q[Q_W-1]};
    assign q_bit  = rem_sh >= {1'b0, den};
    assign trial  = r_res + r_bit;
    assign o_q_rd = (r_state == S_IDLE) & ~i_q_empty;

    assign empty           = ~r_out_valid;
    assign o_any_candidate = r_any;
    assign o_found         = r_found;
    assign o_best_row      = r_orow;
    assign o_best_score_q8 = r_oscore;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_bv        <= 1'b0;
            r_bsum      <= '0;
            r_bcnt      <= '0;
            r_brow      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_rd) begin
                        r_rec   <= i_q_data;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // cross-multiplied score compare, no division
                    r_lhs   <= {11'b0, r_rec.sum} * {21'b0, den};
                    r_rhs   <= {11'b0, r_bsum} * {21'b0, r_rec.runs - CNT_W'(1)};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (take) begin
                        r_bv   <= 1'b1;
                        r_bsum <= r_rec.sum;
                        r_bcnt <= r_rec.runs;
                        r_brow <= r_row;
                    end
                    if (r_row < ROW_CAP) r_row <= r_row + ROW_W'(1);
                    r_state <= r_rec.frame_end ? S_FND1 : S_IDLE;
                end
                S_FND1: begin
                    r_m2    <= {11'b0, i_max_rms} * {11'b0, i_max_rms};
                    r_rem   <= '0;
                    r_q     <= {r_bsum, 16'b0};
                    r_cnt   <= 6'(Q_W - 1);
                    r_state <= S_FND2;
                end
                S_FND2: begin
                    r_m3    <= {11'b0, r_m2} * {22'b0, den};
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem <= q_bit ? (rem_sh - {1'b0, den}) : rem_sh;
                    r_q   <= {r_q[Q_W-2:0], q_bit};
                    if (r_cnt == '0) begin
                        r_v     <= {r_q[Q_W-2:0], q_bit};
                        r_res   <= '0;
                        r_bit   <= R_W'(1) << (Q_W - 1);
                        r_cnt   <= 6'((Q_W - 1) / 2);
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_SQRT: begin
                    // digit-by-digit square root, one result bit per cycle
                    if ({1'b0, r_v} >= trial) begin
                        r_v   <= r_v - trial[Q_W-1:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == '0) r_state <= S_OUT;
                    else r_cnt <= r_cnt - 6'd1;
                end
                S_OUT: begin
                    // hold until the result slot is free
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_any       <= r_bv;
                        r_found     <= r_bv && (den != '0) &&
                                       ({12'b0, r_bsum} < r_m3);
                        r_orow      <= r_bv ? r_brow : '0;
                        if (!r_bv) begin
                            r_oscore <= '0;
                        end else if (den == '0 || r_res > R_W'(SCORE_CAP)) begin
                            r_oscore <= SCORE_CAP;
                        end else begin
                            r_oscore <= r_res[SCORE_W-1:0];
                        end
                        r_row   <= '0;
                        r_bv    <= 1'b0;
                        r_bsum  <= '0;
                        r_bcnt  <= '0;
                        r_brow  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_found_needs_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_found |-> o_any_candidate)
        else $error("found without a qualifying row");
    a_no_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_any_candidate |-> o_best_row == '0 && o_best_score_q8 == '0)
        else $error("nonzero result without a qualifying row");
    a_row_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_CAP)
        else $error("row index past cap");
    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_best_score_q8) && $stable(o_best_row))
        else $error("waiting result overwritten");
`endif

endmodule

/* design/row_run_length_min_rms_select_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_run_length_min_rms_select_unit
// Picks the row of a binary frame with the least RMS of its run lengths.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while full is low. Each row end takes the
// back end through queue read, cross-multiply and compare; a frame end adds
// a threshold multiply, a restoring divide, a square root and the result
// write. A four-row record queue sits between the run tracker and the back
// end; push is held off by full only while that queue is full, which happens
// with rows shorter than three pixels, around a frame end, or while a
// finished result waits to be popped and more rows arrive.
module row_run_length_min_rms_select_unit #(
    parameter int unsigned MAX_WIDTH = rrl_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_ROWS  = rrl_pkg::MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrl_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [rrl_pkg::CFG_D_W-1:0]   i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_pixel,
    input  logic                          i_last_in_row,
    input  logic                          i_last_in_frame,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_any_candidate,
    output logic                          o_found,
    output logic [rrl_pkg::ROW_W-1:0]     o_best_row,
    output logic [rrl_pkg::SCORE_W-1:0]   o_best_score_q8
);
    import rrl_pkg::*;

    logic [MIN_W-1:0] r_min_runs;
    logic [RMS_W-1:0] r_max_rms;
    logic             accept, rec_valid, q_rd, q_empty;
    t_row_rec         rec, q_data;

    assign accept = push & ~full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_runs <= MIN_W'(10);
            r_max_rms  <= RMS_W'(100);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MIN_RUNS: r_min_runs <= i_cfg_data[MIN_W-1:0];
                REG_MAX_RMS:  r_max_rms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rrl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_pixel        (i_pixel),
        .i_last_in_row  (i_last_in_row),
        .i_last_in_frame(i_last_in_frame),
        .o_rec_valid    (rec_valid),
        .o_rec          (rec)
    );

    rrl_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (rec_valid),
        .i_data (rec),
        .i_rd   (q_rd),
        .o_data (q_data),
        .o_full (full),
        .o_empty(q_empty)
    );

    rrl_back #(.MAX_ROWS(MAX_ROWS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_min_runs     (r_min_runs),
        .i_max_rms      (r_max_rms),
        .i_q_empty      (q_empty),
        .i_q_data       (q_data),
        .o_q_rd         (q_rd),
        .empty          (empty),
        .pop            (pop),
        .o_any_candidate(o_any_candidate),
        .o_found        (o_found),
        .o_best_row     (o_best_row),
        .o_best_score_q8(o_best_score_q8)
    );

endmodule
